[rtl/core/ppr_pkg.sv]
package ppr_pkg;

  // Largest row the line store holds, and the column counter width it implies.
  localparam int unsigned MaxWidth = 1024;
  localparam int unsigned ColW     = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;

  // Widths fixed by the register map and the sample format.
  localparam int unsigned SelW    = 3;
  localparam int unsigned WidthW  = 11;
  localparam int unsigned HeightW = 16;
  localparam int unsigned SampleW = 10;
  localparam int unsigned PixW    = 8;
  localparam int unsigned CalcW   = 12;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  // Predictor selection codes.
  typedef enum logic [SelW-1:0] {
    PredLeft     = 3'd0,
    PredAbove    = 3'd1,
    PredAverage  = 3'd2,
    PredPaeth    = 3'd3,
    PredPlanar   = 3'd4,
    PredGradient = 3'd5
  } pred_sel_e;

  // Direction codes.
  typedef enum logic {
    DirEncode = 1'b0,
    DirDecode = 1'b1
  } dir_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    RegPredictor = 2'd0,
    RegDirection = 2'd1,
    RegWidth     = 2'd2,
    RegHeight    = 2'd3
  } cfg_reg_e;

  // Current configuration, shared by the front and back parts.
  typedef struct packed {
    logic [SelW-1:0]    predictor;
    logic               direction;
    logic [WidthW-1:0]  width;
    logic [HeightW-1:0] height;
  } cfg_t;

  // One classified request on its way from the front to the back.
  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic [ColW-1:0]           col;
    logic                      left_ok;
    logic                      above_ok;
    logic                      frame_end;
  } item_t;

  // Head of the queue between front and back.
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  // One finished result.
  typedef struct packed {
    logic signed [SampleW-1:0] value;
    logic                      frame_end;
  } result_t;

endpackage

[rtl/core/ppr_ram.sv]
module ppr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  logic [Width-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_i,
  output logic [Width-1:0]                 rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/ppr_front.sv]
module ppr_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ppr_pkg::cfg_t                        cfg_i,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [ppr_pkg::SampleW-1:0]   sample_i,
  output ppr_pkg::head_t                       head_o,
  input  logic                                 pop_i
);

  logic [ppr_pkg::ColW-1:0]    column_q, column_d;
  logic [ppr_pkg::HeightW-1:0] row_q, row_d;
  logic [16:0]                 width_eff, height_eff;
  logic                        last_col, last_row, accept;
  ppr_pkg::item_t              item;

  ppr_pkg::item_t              mem_q [2];
  logic                        wptr_q, rptr_q;
  logic [1:0]                  cnt_q, cnt_d;

  assign full   = (cnt_q == 2'd2);
  assign accept = push && !full;

  // Effective frame size: zero acts as one, widths beyond the line store saturate.
  always_comb begin
    width_eff = 17'(cfg_i.width);
    if (cfg_i.width == '0) begin
      width_eff = 17'd1;
    end else if (17'(cfg_i.width) > 17'(ppr_pkg::MaxWidth)) begin
      width_eff = 17'(ppr_pkg::MaxWidth);
    end
    height_eff = 17'(cfg_i.height);
    if (cfg_i.height == '0) begin
      height_eff = 17'd1;
    end
  end

  assign last_col = (17'(column_q) + 17'd1) >= width_eff;
  assign last_row = (17'(row_q) + 17'd1) >= height_eff;

  // Classify the request by its place in the frame.
  always_comb begin
    item.sample    = sample_i;
    item.col       = column_q;
    item.left_ok   = (column_q != '0);
    item.above_ok  = (row_q != '0);
    item.frame_end = last_col && last_row;
  end

  // Raster position for the next request.
  always_comb begin
    column_d = column_q;
    row_d    = row_q;
    if (accept) begin
      if (last_col) begin
        column_d = '0;
        row_d    = last_row ? '0 : row_q + 1'b1;
      end else begin
        column_d = column_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      row_q    <= '0;
    end else begin
      column_q <= column_d;
      row_q    <= row_d;
    end
  end

  // Two-entry queue toward the back part.
  always_comb begin
    cnt_d = cnt_q;
    if (accept && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!accept && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[wptr_q] <= item;
    end
  end

  assign head_o = {(cnt_q != 2'd0), mem_q[rptr_q]};

endmodule

[rtl/core/ppr_back.sv]
module ppr_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ppr_pkg::cfg_t                        cfg_i,
  input  ppr_pkg::head_t                       head_i,
  output logic                                 pop_o,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [ppr_pkg::SampleW-1:0]   value_o,
  output logic                                 frame_end_o
);

  localparam int unsigned CW = ppr_pkg::CalcW;

  // Working stage.
  logic                         stg_valid_q, stg_valid_d;
  ppr_pkg::item_t               stg_q;
  logic                         byp_q;
  logic [ppr_pkg::PixW-1:0]     byp_pix_q;
  logic [ppr_pkg::PixW-1:0]     left_q, upper_q;
  logic                         fire, load;

  // Prediction datapath.
  logic [ppr_pkg::PixW-1:0]     rdata, b_raw, a, b, c;
  logic signed [CW-1:0]         sa, sb, sc, s_ext, pred, grad_d, grad_h;
  logic signed [CW-1:0]         pa, pb, pc, paeth_p, sum;
  logic [ppr_pkg::PixW-1:0]     pixel, paeth_pix;
  logic signed [CW-1:0]         result;
  ppr_pkg::result_t             res;

  // Output queue.
  ppr_pkg::result_t             out_q [2];
  logic                         owptr_q, orptr_q;
  logic [1:0]                   ocnt_q, ocnt_d;
  logic                         out_full, out_pop;

  function automatic logic signed [CW-1:0] abs_s(input logic signed [CW-1:0] v);
    abs_s = v[CW-1] ? -v : v;
  endfunction

  function automatic logic [ppr_pkg::PixW-1:0] clamp_pix(input logic signed [CW-1:0] v);
    if (v < 0) begin
      clamp_pix = '0;
    end else if (v > CW'(255)) begin
      clamp_pix = '1;
    end else begin
      clamp_pix = v[ppr_pkg::PixW-1:0];
    end
  endfunction

  assign out_full = (ocnt_q == 2'd2);
  assign fire     = stg_valid_q && !out_full;
  assign load     = head_i.valid && (!stg_valid_q || fire);
  assign pop_o    = load;

  // Line store holding the previous row.
  ppr_ram #(
    .Width (ppr_pkg::PixW),
    .Depth (ppr_pkg::MaxWidth)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (fire),
    .waddr_i (stg_q.col),
    .wdata_i (pixel),
    .re_i    (load),
    .raddr_i (head_i.item.col),
    .rdata_o (rdata)
  );

  // Neighbors; a write to the same column in the read cycle is forwarded.
  always_comb begin
    b_raw = byp_q ? byp_pix_q : rdata;
    a     = stg_q.left_ok ? left_q : '0;
    b     = stg_q.above_ok ? b_raw : '0;
    c     = (stg_q.left_ok && stg_q.above_ok) ? upper_q : '0;
    sa    = $signed({4'b0, a});
    sb    = $signed({4'b0, b});
    sc    = $signed({4'b0, c});
    s_ext = CW'(stg_q.sample);
  end

  // Paeth: closest of left, above and upper-left to the planar estimate.
  always_comb begin
    paeth_p = sa + sb - sc;
    pa      = abs_s(paeth_p - sa);
    pb      = abs_s(paeth_p - sb);
    pc      = abs_s(paeth_p - sc);
    if (pa <= pb && pa <= pc) begin
      paeth_pix = a;
    end else if (pb <= pc) begin
      paeth_pix = b;
    end else begin
      paeth_pix = c;
    end
  end

  // Gradient half-difference, truncated toward zero.
  always_comb begin
    grad_d = sb - sc;
    grad_h = grad_d[CW-1] ? -((-grad_d) >>> 1) : (grad_d >>> 1);
  end

  // Predictor selection; unused codes predict zero.
  always_comb begin
    sum = sa + sb;
    unique case (cfg_i.predictor)
      ppr_pkg::PredLeft:     pred = sa;
      ppr_pkg::PredAbove:    pred = sb;
      ppr_pkg::PredAverage:  pred = sum >>> 1;
      ppr_pkg::PredPaeth:    pred = $signed({4'b0, paeth_pix});
      ppr_pkg::PredPlanar:   pred = sa + sb - sc;
      ppr_pkg::PredGradient: pred = sa + grad_h;
      default:               pred = '0;
    endcase
  end

  // Residual in encode direction, clamped reconstruction in decode direction.
  always_comb begin
    if (cfg_i.direction == ppr_pkg::DirDecode) begin
      pixel  = clamp_pix(pred + s_ext);
      result = $signed({4'b0, pixel});
    end else begin
      pixel  = clamp_pix(s_ext);
      result = $signed({4'b0, pixel}) - pred;
    end
    res.value     = result[ppr_pkg::SampleW-1:0];
    res.frame_end = stg_q.frame_end;
  end

  // Stage occupancy.
  always_comb begin
    stg_valid_d = stg_valid_q;
    if (load) begin
      stg_valid_d = 1'b1;
    end else if (fire) begin
      stg_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      left_q      <= '0;
      upper_q     <= '0;
    end else begin
      stg_valid_q <= stg_valid_d;
      if (fire) begin
        left_q  <= pixel;
        upper_q <= b_raw;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      stg_q     <= head_i.item;
      byp_q     <= fire && (stg_q.col == head_i.item.col);
      byp_pix_q <= pixel;
    end
  end

  // Two-entry result queue.
  assign out_pop = pop && !empty;

  always_comb begin
    ocnt_d = ocnt_q;
    if (fire && !out_pop) begin
      ocnt_d = ocnt_q + 2'd1;
    end else if (!fire && out_pop) begin
      ocnt_d = ocnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owptr_q <= 1'b0;
      orptr_q <= 1'b0;
      ocnt_q  <= 2'd0;
    end else begin
      ocnt_q <= ocnt_d;
      if (fire) begin
        owptr_q <= ~owptr_q;
      end
      if (out_pop) begin
        orptr_q <= ~orptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q[owptr_q] <= res;
    end
  end

  assign empty       = (ocnt_q == 2'd0);
  assign value_o     = out_q[orptr_q].value;
  assign frame_end_o = out_q[orptr_q].frame_end;

endmodule

[rtl/core/pixel_prediction_residual_unit.sv]
// A result goes through the front queue, working stage and result queue to the result ports.
// Throughput: one pixel per cycle while the result queue has room, set by the left neighbor
// loop through predictor and clamp, and by the one read and one write port of the line store.
// Reset clears configuration to its defaults, the raster position, both neighbor registers
// and both queues; the line store keeps its contents and is not swept.
module pixel_prediction_residual_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input side.
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [ppr_pkg::SampleW-1:0]   sample_i,
  // Result side.
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [ppr_pkg::SampleW-1:0]   value_o,
  output logic                                 frame_end_o,
  // Configuration writes.
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ppr_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [ppr_pkg::CfgDatW-1:0]          cfg_data_i
);

  ppr_pkg::cfg_t  cfg_q, cfg_d;
  ppr_pkg::head_t head;
  logic           head_pop;

  assign cfg_ready_o = 1'b1;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (ppr_pkg::cfg_reg_e'(cfg_index_i))
        ppr_pkg::RegPredictor: cfg_d.predictor = cfg_data_i[ppr_pkg::SelW-1:0];
        ppr_pkg::RegDirection: cfg_d.direction = cfg_data_i[0];
        ppr_pkg::RegWidth:     cfg_d.width     = cfg_data_i[ppr_pkg::WidthW-1:0];
        ppr_pkg::RegHeight:    cfg_d.height    = cfg_data_i[ppr_pkg::HeightW-1:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.predictor <= ppr_pkg::PredLeft;
      cfg_q.direction <= ppr_pkg::DirEncode;
      cfg_q.width     <= ppr_pkg::WidthW'(1024);
      cfg_q.height    <= ppr_pkg::HeightW'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front part: raster position, classification and the queue toward the back part.
  ppr_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .push     (push),
    .full     (full),
    .sample_i (sample_i),
    .head_o   (head),
    .pop_i    (head_pop)
  );

  // Back part: line store, prediction and result queue.
  ppr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .pop_o       (head_pop),
    .empty       (empty),
    .pop         (pop),
    .value_o     (value_o),
    .frame_end_o (frame_end_o)
  );

endmodule
